### hw/rtl/soc_pkg.sv
package soc_pkg;

  localparam int VAL_W       = 32;
  localparam int SUM_W       = 64;
  localparam int CNT_W       = 6;
  localparam int MAX_DIM_DEF = 32;

  typedef struct packed {
    logic signed [VAL_W-1:0] head;
    logic [SUM_W-1:0]        sum;
    logic [CNT_W-1:0]        count;
    logic                    drop;
  } job_t;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_ZERO,
    MODE_SCALE
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_DEC,
    ST_HEAD,
    ST_RD,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

### hw/rtl/soc_front.sv
module soc_front
  import soc_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_last,
  input  logic                    back_idle,
  input  logic                    job_pop,
  output logic                    job_valid,
  output job_t                    job,
  input  logic [IDX_W-1:0]        rd_addr,
  output logic signed [VAL_W-1:0] rd_data
);

  logic signed [VAL_W-1:0] mem [MAX_DIM];

  logic signed [VAL_W-1:0] head_r;
  logic                    in_vec_r;
  logic [CNT_W-1:0]        count_r;
  logic [SUM_W-1:0]        sum_r;
  logic                    ovf_r;
  logic                    last_seen_r;
  logic                    s1_v_r, s1_comp_r, s1_last_r;
  logic [VAL_W-1:0]        mag_r;
  logic                    s2_v_r, s2_comp_r, s2_last_r;
  logic [SUM_W-1:0]        sq_r;
  logic                    job_v_r;
  job_t                    job_r;
  logic signed [VAL_W-1:0] rd_data_r;

  logic             accept;
  logic             store;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_nxt;

  assign busy      = last_seen_r | job_v_r | ~back_idle;
  assign accept    = start & ~busy;
  assign store     = accept & in_vec_r & (count_r < CNT_W'(MAX_DIM));
  assign job_valid = job_v_r;
  assign job       = job_r;
  assign rd_data   = rd_data_r;

  assign sum_add = {1'b0, sum_r} + {1'b0, sq_r};
  always_comb begin
    sum_nxt = sum_r;
    if (s2_v_r && s2_comp_r) begin
      sum_nxt = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[count_r[IDX_W-1:0]] <= in_value;
    end
    rd_data_r <= mem[rd_addr];
    mag_r     <= in_value[VAL_W-1] ? VAL_W'(-in_value) : in_value;
    sq_r      <= SUM_W'(mag_r) * SUM_W'(mag_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      in_vec_r    <= 1'b0;
      count_r     <= '0;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      last_seen_r <= 1'b0;
      s1_v_r      <= 1'b0;
      s1_comp_r   <= 1'b0;
      s1_last_r   <= 1'b0;
      s2_v_r      <= 1'b0;
      s2_comp_r   <= 1'b0;
      s2_last_r   <= 1'b0;
      job_v_r     <= 1'b0;
      job_r       <= '0;
    end else begin
      s1_v_r    <= accept;
      s1_comp_r <= store;
      s1_last_r <= accept & in_last;
      s2_v_r    <= s1_v_r;
      s2_comp_r <= s1_comp_r;
      s2_last_r <= s1_v_r & s1_last_r;
      if (job_pop) begin
        job_v_r <= 1'b0;
      end
      if (accept) begin
        if (in_last) begin
          last_seen_r <= 1'b1;
        end
        if (!in_vec_r) begin
          head_r   <= in_value;
          in_vec_r <= 1'b1;
        end else if (store) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      // hand the finished vector to the back end and clear for the next one
      if (s2_v_r && s2_last_r) begin
        job_v_r     <= 1'b1;
        job_r       <= '{head: head_r, sum: sum_nxt, count: count_r, drop: ovf_r};
        head_r      <= '0;
        in_vec_r    <= 1'b0;
        count_r     <= '0;
        sum_r       <= '0;
        ovf_r       <= 1'b0;
        last_seen_r <= 1'b0;
      end else begin
        sum_r <= sum_nxt;
      end
    end
  end

endmodule

### hw/rtl/soc_back.sv
module soc_back
  import soc_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_valid,
  input  job_t                    job,
  output logic                    job_pop,
  output logic                    back_idle,
  output logic [IDX_W-1:0]        rd_addr,
  input  logic signed [VAL_W-1:0] rd_data,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_result_value,
  output logic                    out_result_last,
  output logic                    out_dropped
);

  localparam int STEP_W = $clog2(VAL_W);

  state_t                  state_r, state_nxt;
  mode_t                   mode_r, mode_nxt;
  logic signed [VAL_W-1:0] t_r, t_nxt;
  logic [SUM_W-1:0]        rad_r, rad_nxt;
  logic [VAL_W+1:0]        srem_r, srem_nxt;
  logic [VAL_W-1:0]        root_r, root_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic [CNT_W-1:0]        i_r, i_nxt;
  logic                    drop_r, drop_nxt;
  logic [VAL_W-1:0]        alpha_r, alpha_nxt;
  logic [SUM_W-1:0]        prod_r, prod_nxt;
  logic                    xneg_r, xneg_nxt;
  logic [VAL_W-1:0]        drem_r, drem_nxt;
  logic [VAL_W-1:0]        quo_r, quo_nxt;
  logic                    ov_r, ov_nxt;
  logic signed [VAL_W-1:0] ovalue_r, ovalue_nxt;
  logic                    olast_r, olast_nxt;

  logic [VAL_W+1:0]        s_try, s_trial;
  logic [VAL_W:0]          d_try;
  logic signed [VAL_W+1:0] t_ext, n_ext, tn_sum;
  logic [VAL_W-1:0]        xmag;
  logic [CNT_W-1:0]        i_inc;

  assign back_idle        = (state_r == ST_IDLE);
  assign rd_addr          = i_r[IDX_W-1:0];
  assign out_valid        = ov_r;
  assign out_result_value = ovalue_r;
  assign out_result_last  = olast_r;
  assign out_dropped      = drop_r;

  assign s_try   = {srem_r[VAL_W-1:0], rad_r[SUM_W-1 -: 2]};
  assign s_trial = {root_r, 2'b01};
  assign d_try   = {drem_r, prod_r[SUM_W-1]};
  assign t_ext   = (VAL_W+2)'(t_r);
  assign n_ext   = $signed({2'b00, root_r});
  assign tn_sum  = t_ext + n_ext;
  assign xmag    = rd_data[VAL_W-1] ? VAL_W'(-rd_data) : rd_data;
  assign i_inc   = i_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    t_r      <= t_nxt;
    rad_r    <= rad_nxt;
    srem_r   <= srem_nxt;
    root_r   <= root_nxt;
    step_r   <= step_nxt;
    n_r      <= n_nxt;
    i_r      <= i_nxt;
    drop_r   <= drop_nxt;
    alpha_r  <= alpha_nxt;
    prod_r   <= prod_nxt;
    xneg_r   <= xneg_nxt;
    drem_r   <= drem_nxt;
    quo_r    <= quo_nxt;
    ovalue_r <= ovalue_nxt;
    olast_r  <= olast_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    t_nxt      = t_r;
    rad_nxt    = rad_r;
    srem_nxt   = srem_r;
    root_nxt   = root_r;
    step_nxt   = step_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    drop_nxt   = drop_r;
    alpha_nxt  = alpha_r;
    prod_nxt   = prod_r;
    xneg_nxt   = xneg_r;
    drem_nxt   = drem_r;
    quo_nxt    = quo_r;
    ov_nxt     = 1'b0;
    ovalue_nxt = ovalue_r;
    olast_nxt  = olast_r;
    job_pop    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          t_nxt     = job.head;
          rad_nxt   = job.sum;
          n_nxt     = job.count;
          drop_nxt  = job.drop;
          srem_nxt  = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // one root bit per cycle
        rad_nxt = rad_r << 2;
        if (s_try >= s_trial) begin
          srem_nxt = s_try - s_trial;
          root_nxt = {root_r[VAL_W-2:0], 1'b1};
        end else begin
          srem_nxt = s_try;
          root_nxt = {root_r[VAL_W-2:0], 1'b0};
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(VAL_W-1)) begin
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        alpha_nxt = tn_sum[VAL_W:1];
        if (n_ext <= t_ext) begin
          mode_nxt = MODE_PASS;
        end else if (n_ext <= -t_ext) begin
          mode_nxt = MODE_ZERO;
        end else begin
          mode_nxt = MODE_SCALE;
        end
        state_nxt = ST_HEAD;
      end
      ST_HEAD: begin
        ov_nxt    = 1'b1;
        olast_nxt = (n_r == '0);
        unique case (mode_r)
          MODE_PASS:  ovalue_nxt = t_r;
          MODE_ZERO:  ovalue_nxt = '0;
          default: begin
            ovalue_nxt = alpha_r[VAL_W-1] ? {1'b0, {(VAL_W-1){1'b1}}} : alpha_r;
          end
        endcase
        i_nxt     = '0;
        state_nxt = (n_r == '0) ? ST_IDLE : ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mode_r == MODE_SCALE && root_r != '0) begin
          prod_nxt  = SUM_W'(xmag) * SUM_W'(alpha_r);
          xneg_nxt  = rd_data[VAL_W-1];
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end else begin
          ov_nxt     = 1'b1;
          olast_nxt  = (i_inc == n_r);
          ovalue_nxt = (mode_r == MODE_PASS) ? rd_data : '0;
          i_nxt      = i_inc;
          state_nxt  = (i_inc == n_r) ? ST_IDLE : ST_RD;
        end
      end
      ST_DIV: begin
        // high half is below the norm, so the quotient fits one word
        if (step_r == '0) begin
          drem_nxt = prod_r[SUM_W-1:VAL_W];
          quo_nxt  = '0;
          prod_nxt = {prod_r[VAL_W-1:0], {VAL_W{1'b0}}};
          step_nxt = STEP_W'(1);
        end else begin
          if (d_try >= {1'b0, root_r}) begin
            drem_nxt = VAL_W'(d_try - {1'b0, root_r});
            quo_nxt  = {quo_r[VAL_W-2:0], 1'b1};
          end else begin
            drem_nxt = d_try[VAL_W-1:0];
            quo_nxt  = {quo_r[VAL_W-2:0], 1'b0};
          end
          prod_nxt = prod_r << 1;
          step_nxt = step_r + STEP_W'(1);
          if (step_r == STEP_W'(VAL_W-1)) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // last quotient bit
        if (d_try >= {1'b0, root_r}) begin
          quo_nxt = {quo_r[VAL_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_r[VAL_W-2:0], 1'b0};
        end
        ov_nxt     = 1'b1;
        olast_nxt  = (i_inc == n_r);
        ovalue_nxt = xneg_r ? VAL_W'(-quo_nxt) : quo_nxt;
        i_nxt      = i_inc;
        state_nxt  = (i_inc == n_r) ? ST_IDLE : ST_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/second_order_cone_projection.sv
// Channel  | Ports                                          | Transfer
// input    | in_value, in_last                              | start && !busy
// result   | out_result_value, out_result_last, out_dropped | out_valid strobe
//
// Components load back to back: busy stays low while a vector loads,
// then holds from the cycle after the closing transfer until the final result.
// After the last component the sum is closed, the square root is taken and
// the head is classified and t emitted; then each component is read and emitted
// directly when passed or zeroed, through a divide when scaled (one quotient bit per cycle).
// Reset (rst_n low, synchronous) drops any vector in progress.
// Results are one-cycle strobes; the receiver cannot stall them.
module second_order_cone_projection
  import soc_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_last,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_result_value,
  output logic                    out_result_last,
  output logic                    out_dropped
);

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic                    back_idle;
  logic                    job_pop;
  logic                    job_valid;
  job_t                    job;
  logic [IDX_W-1:0]        rd_addr;
  logic signed [VAL_W-1:0] rd_data;

  soc_front #(.MAX_DIM(MAX_DIM), .IDX_W(IDX_W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_value  (in_value),
    .in_last   (in_last),
    .back_idle (back_idle),
    .job_pop   (job_pop),
    .job_valid (job_valid),
    .job       (job),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  soc_back #(.MAX_DIM(MAX_DIM), .IDX_W(IDX_W)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (job_valid),
    .job              (job),
    .job_pop          (job_pop),
    .back_idle        (back_idle),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_result_last  (out_result_last),
    .out_dropped      (out_dropped)
  );

endmodule

### hw/rtl/soc_checker.sv
module soc_assertions
  import soc_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic signed [VAL_W-1:0] in_value,
  input logic                    in_last,
  input logic                    out_valid,
  input logic signed [VAL_W-1:0] out_result_value,
  input logic                    out_result_last,
  input logic                    out_dropped
);

  // a closing transfer must hold off the next vector
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last |=> busy)
    else $error("no busy after last transfer");

  // the block stays busy while more results of the vector follow
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_last |-> busy)
    else $error("not busy while results remain");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_last |=> !out_valid)
    else $error("result right after final result");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind second_order_cone_projection soc_assertions u_soc_assertions (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_value         (in_value),
  .in_last          (in_last),
  .out_valid        (out_valid),
  .out_result_value (out_result_value),
  .out_result_last  (out_result_last),
  .out_dropped      (out_dropped)
);

### bench/soc_checker.sv
`timescale 1ns / 100ps

module soc_checker
  import soc_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_last,
  input  logic                    out_valid,
  input  logic signed [VAL_W-1:0] out_result_value,
  input  logic                    out_result_last,
  input  logic                    out_dropped,
  output int                      fail_count,
  output int                      pending
);

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    dropped;
  } projected_t;

  projected_t projected_q[$];

  // predictor copy of the vector being loaded
  logic signed [VAL_W-1:0] cone_head;
  bit                      head_taken;
  logic signed [VAL_W-1:0] x_store[MAX_DIM];
  int                      x_count;
  bit [SUM_W-1:0]          sq_total;
  bit                      too_long;

  function automatic bit [63:0] floor_root(bit [63:0] v);
    bit [63:0] root;
    bit [63:0] trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [VAL_W-1:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[VAL_W-1:0];
  endfunction

  task automatic take_component(logic signed [VAL_W-1:0] v, logic lst);
    bit [63:0]  mag;
    bit [63:0]  sq;
    bit [63:0]  prod;
    bit [63:0]  q;
    longint     t;
    longint     norm;
    longint     alpha;
    longint     r;
    mode_t      mode;
    projected_t p;
    mag = (v < 0) ? 64'(-longint'(v)) : 64'(longint'(v));
    if (!head_taken) begin
      cone_head  = v;
      head_taken = 1;
    end else if (x_count < MAX_DIM) begin
      sq = mag * mag;
      x_store[x_count] = v;
      x_count++;
      if (sq_total > ~64'd0 - sq) sq_total = ~64'd0;
      else sq_total += sq;
    end else begin
      too_long = 1;
    end
    if (!lst) return;

    t     = cone_head;
    norm  = longint'(floor_root(sq_total));
    alpha = 0;
    if (norm <= t) mode = MODE_PASS;
    else if (norm <= -t) mode = MODE_ZERO;
    else begin
      mode  = MODE_SCALE;
      alpha = (t + norm) / 2;
    end

    p.value   = (mode == MODE_PASS) ? clamp32(t) :
                (mode == MODE_ZERO) ? '0 : clamp32(alpha);
    p.last    = (x_count == 0);
    p.dropped = too_long;
    projected_q.push_back(p);
    for (int i = 0; i < x_count; i++) begin
      if (mode == MODE_PASS) r = x_store[i];
      else if (mode == MODE_ZERO || norm <= 0) r = 0;
      else begin
        mag  = (x_store[i] < 0) ? 64'(-longint'(x_store[i])) : 64'(longint'(x_store[i]));
        prod = mag * 64'(alpha);
        q    = prod / 64'(norm);
        if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
        r = (x_store[i] < 0) ? -longint'(q) : longint'(q);
      end
      p.value = clamp32(r);
      p.last  = (i + 1 == x_count);
      projected_q.push_back(p);
    end
    head_taken = 0;
    cone_head  = 0;
    x_count    = 0;
    sq_total   = 0;
    too_long   = 0;
  endtask

  always @(posedge clk) begin
    projected_t want;
    if (!rst_n) begin
      projected_q.delete();
      head_taken = 0;
      cone_head  = 0;
      x_count    = 0;
      sq_total   = 0;
      too_long   = 0;
    end else begin
      if (out_valid) begin
        if (projected_q.size() == 0) begin
          $display("%0t: result with nothing expected: actual value %h last %b dropped %b",
                   $time, out_result_value, out_result_last, out_dropped);
          fail_count++;
        end else begin
          want = projected_q.pop_front();
          if (want.value !== out_result_value || want.last !== out_result_last ||
              want.dropped !== out_dropped) begin
            $display("%0t: mismatch: expected value %h last %b dropped %b, actual %h %b %b",
                     $time, want.value, want.last, want.dropped,
                     out_result_value, out_result_last, out_dropped);
            fail_count++;
          end
        end
      end
      if (start && !busy) take_component(in_value, in_last);
    end
    pending = projected_q.size();
  end

  initial begin
    fail_count = 0;
    pending    = 0;
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import soc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEM_TARGET    = 460;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [VAL_W-1:0] in_value;
  logic                    in_last;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_result_value;
  logic                    out_result_last;
  logic                    out_dropped;
  int                      fail_count;
  int                      pending;
  int                      idle_cycles;
  int                      items_sent;
  bit                      no_gaps;

  second_order_cone_projection dut (
    .clk, .rst_n, .start, .busy, .in_value, .in_last,
    .out_valid, .out_result_value, .out_result_last, .out_dropped
  );

  soc_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_value, .in_last,
    .out_valid, .out_result_value, .out_result_last, .out_dropped,
    .fail_count, .pending
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // watchdog: count cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(logic signed [VAL_W-1:0] v, logic lst);
    int gap;
    start    <= 1'b1;
    in_value <= v;
    in_last  <= lst;
    do @(posedge clk); while (busy);
    items_sent++;
    gap = no_gaps ? 0 : $urandom_range(16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(255)) - 128;
      default: return ($signed($urandom_range(2047)) - 1024) <<< 12;
    endcase
  endfunction

  task automatic send_vector();
    int nx;
    int r;
    r = $urandom_range(99);
    if (r < 6) nx = 0;
    else if (r < 70) nx = $urandom_range(6, 1);
    else if (r < 90) nx = $urandom_range(32, 7);
    else nx = $urandom_range(36, 33);
    no_gaps = ($urandom_range(3) == 0);
    send(pick_value(), nx == 0);
    for (int i = 1; i <= nx; i++) send(pick_value(), i == nx);
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_value    = '0;
    in_last     = 1'b0;
    idle_cycles = 0;
    items_sent  = 0;
    no_gaps     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // head only: positive, negative, extremes
    send(32'sh0001_0000, 1'b1);
    send(-32'sh0003_0000, 1'b1);
    send(32'sh7fffffff, 1'b1);
    send(32'sh80000000, 1'b1);
    // extreme components, scaled
    send(32'sh7fffffff, 1'b0);
    send(32'sh7fffffff, 1'b0);
    send(32'sh80000000, 1'b1);
    // zero norm with negative head
    send(-32'sh0000_0001, 1'b0);
    send('0, 1'b0);
    send('0, 1'b1);
    // zero head, zero norm
    send('0, 1'b0);
    send('0, 1'b1);
    // scaled: t = 1, x = (3, 4)
    send(32'sh0001_0000, 1'b0);
    send(32'sh0003_0000, 1'b0);
    send(-32'sh0004_0000, 1'b1);
    // saturated square sum
    send('0, 1'b0);
    repeat (3) send(32'sh80000000, 1'b0);
    send(32'sh80000000, 1'b1);

    while (items_sent < ITEM_TARGET) send_vector();
    start <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
